@@ hw/rtl/pcdft_pkg.sv @@
package pcdft_pkg;

	// Sizes fixed by the item and register formats.
	localparam int PCDFT_CHANNELS = 32;
	localparam int VALUE_W        = 16;
	localparam int CHANNEL_W      = 5;
	localparam int SIGN_W         = 2;
	localparam int ALG_W          = 2;
	localparam int CFG_INDEX_W    = 2;
	localparam int CFG_DATA_W     = 16;

	// Register reset values.
	localparam logic [VALUE_W-1:0] MIN_RESET  = 16'd0;
	localparam logic [VALUE_W-1:0] MAX_RESET  = 16'd255;
	localparam logic [VALUE_W-1:0] STEP_RESET = 16'd1;

	// Register indexes on the configuration port.
	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_MIN_VALUE    = 2'd0,
		CFG_MAX_VALUE    = 2'd1,
		CFG_INITIAL_STEP = 2'd2,
		CFG_ALGORITHM    = 2'd3
	} cfg_idx_t;

	// Algorithm codes; the remaining code behaves as the unit step.
	localparam logic [ALG_W-1:0] ALG_SIGN_CHANGE = 2'd0;
	localparam logic [ALG_W-1:0] ALG_BINARY      = 2'd1;
	localparam logic [ALG_W-1:0] ALG_UNIT        = 2'd2;

	// Item modes.
	localparam logic MODE_INIT     = 1'b0;
	localparam logic MODE_FEEDBACK = 1'b1;

	// Stored prior sign codes.
	localparam logic [SIGN_W-1:0] SIGN_NONE  = 2'b00;
	localparam logic [SIGN_W-1:0] SIGN_PLUS  = 2'b01;
	localparam logic [SIGN_W-1:0] SIGN_MINUS = 2'b11;

	// Controller states.
	typedef enum logic {
		ST_IDLE,
		ST_CALC
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic compute;
	} cmd_t;

endpackage

@@ hw/rtl/pcdft_if.sv @@
// Input item channel.
interface pcdft_in_if
	import pcdft_pkg::*;
();
	logic                        valid;
	logic                        ready;
	logic                        mode;
	logic [CHANNEL_W-1:0]        channel;
	logic signed [SIGN_W-1:0]    sign;
	logic                        last;

	modport source (output valid, mode, channel, sign, last, input ready);
	modport sink   (input valid, mode, channel, sign, last, output ready);
endinterface

// Result item channel.
interface pcdft_out_if
	import pcdft_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CHANNEL_W-1:0]  out_channel;
	logic [VALUE_W-1:0]    tuned_value;
	logic [VALUE_W-1:0]    current_step;
	logic                  channel_done;

	modport source (output valid, out_channel, tuned_value, current_step, channel_done,
		input ready);
	modport sink   (input valid, out_channel, tuned_value, current_step, channel_done,
		output ready);
endinterface

@@ hw/rtl/pcdft_ctrl.sv @@
module pcdft_ctrl
	import pcdft_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	// State register and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.compute) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and commands. A result is computed once the output register is free.
	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.compute = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid) begin
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				if (!out_valid_q || out_ready) begin
					cmd.compute = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

@@ hw/rtl/pcdft_dp.sv @@
module pcdft_dp
	import pcdft_pkg::*;
#(
	parameter int CHANNELS = PCDFT_CHANNELS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	input  logic                     cfg_we,
	input  logic [CFG_INDEX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	input  logic                     mode,
	input  logic [CHANNEL_W-1:0]     channel,
	input  logic signed [SIGN_W-1:0] sign,
	input  logic                     last,
	output logic [CHANNEL_W-1:0]     out_channel,
	output logic [VALUE_W-1:0]       tuned_value,
	output logic [VALUE_W-1:0]       current_step,
	output logic                     channel_done
);

	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SW = VALUE_W + 2;

	logic [VALUE_W-1:0] min_q;
	logic [VALUE_W-1:0] max_q;
	logic [VALUE_W-1:0] init_step_q;
	logic [ALG_W-1:0]   alg_q;

	// Per-channel state memories.
	logic [VALUE_W-1:0] value_mem [CHANNELS];
	logic [VALUE_W-1:0] step_mem  [CHANNELS];
	logic [SIGN_W-1:0]  prior_mem [CHANNELS];
	logic               done_mem  [CHANNELS];

	logic               mode_q;
	logic [CHANNEL_W-1:0] channel_q;
	logic [SIGN_W-1:0]  sign_q;
	logic               last_q;
	logic               in_range_q;
	logic [VALUE_W-1:0] rd_value_q;
	logic [VALUE_W-1:0] rd_step_q;
	logic [SIGN_W-1:0]  rd_prior_q;
	logic               rd_done_q;

	logic [8:0]         ch_in_ext;
	logic [8:0]         ch_q_ext;
	logic [AW-1:0]      rd_addr;
	logic [AW-1:0]      wr_addr;
	logic               in_range;

	logic               s_pos;
	logic               s_neg;
	logic [SIGN_W-1:0]  s_code;
	logic [VALUE_W-1:0] step_sel;
	logic [VALUE_W-1:0] step_half;
	logic signed [SW-1:0] delta;
	logic signed [SW-1:0] sum;
	logic signed [SW-1:0] max_ext;
	logic signed [SW-1:0] min_ext;
	logic signed [SW-1:0] clamp_a;
	logic [VALUE_W-1:0] new_value;
	logic [VALUE_W-1:0] new_step;
	logic [SIGN_W-1:0]  new_prior;
	logic               new_done;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q       <= MIN_RESET;
			max_q       <= MAX_RESET;
			init_step_q <= STEP_RESET;
			alg_q       <= ALG_SIGN_CHANGE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MIN_VALUE:    min_q       <= cfg_data[VALUE_W-1:0];
				CFG_MAX_VALUE:    max_q       <= cfg_data[VALUE_W-1:0];
				CFG_INITIAL_STEP: init_step_q <= cfg_data[VALUE_W-1:0];
				CFG_ALGORITHM:    alg_q       <= cfg_data[ALG_W-1:0];
				default: ;
			endcase
		end
	end

	// Channel addressing; channels beyond the store leave no trace.
	assign ch_in_ext = {{(9-CHANNEL_W){1'b0}}, channel};
	assign ch_q_ext  = {{(9-CHANNEL_W){1'b0}}, channel_q};
	assign rd_addr   = ch_in_ext[AW-1:0];
	assign wr_addr   = ch_q_ext[AW-1:0];
	assign in_range  = (ch_in_ext < 9'(CHANNELS));

	// Capture the item and read the channel's state on the accepted beat.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q     <= mode;
			channel_q  <= channel;
			sign_q     <= sign;
			last_q     <= last;
			in_range_q <= in_range;
			if (in_range) begin
				rd_value_q <= value_mem[rd_addr];
				rd_step_q  <= step_mem[rd_addr];
				rd_prior_q <= prior_mem[rd_addr];
				rd_done_q  <= done_mem[rd_addr];
			end
		end
	end

	// Update rule for the selected algorithm.
	always_comb begin
		s_pos     = (sign_q == SIGN_PLUS);
		s_neg     = sign_q[1];
		s_code    = s_neg ? SIGN_MINUS : (s_pos ? SIGN_PLUS : SIGN_NONE);
		step_half = rd_step_q >> 1;
		max_ext   = $signed({2'b00, max_q});
		min_ext   = $signed({2'b00, min_q});
		step_sel  = rd_step_q;
		new_prior = rd_prior_q;
		new_step  = rd_step_q;
		new_done  = rd_done_q | last_q;
		clamp_a   = '0;
		case (alg_q)
			ALG_SIGN_CHANGE: begin
				if (s_code != rd_prior_q) begin
					new_prior = SIGN_NONE;
					step_sel  = step_half;
				end
				new_step = step_sel;
			end
			ALG_BINARY: begin
				new_step = step_half;
			end
			default: begin
				step_sel = {{(VALUE_W-1){1'b0}}, 1'b1};
			end
		endcase
		delta = s_pos ? $signed({2'b00, step_sel})
			: (s_neg ? -$signed({2'b00, step_sel}) : '0);
		sum   = $signed({2'b00, rd_value_q}) + delta;
		case (alg_q)
			ALG_SIGN_CHANGE: begin
				clamp_a   = (sum > max_ext) ? max_ext : sum;
				new_value = (clamp_a < min_ext) ? min_q : clamp_a[VALUE_W-1:0];
				if (step_sel == 16'd1 || new_value <= min_q) begin
					new_done = 1'b1;
				end
			end
			default: begin
				if (sum < 0) begin
					new_value = '0;
				end else if (sum[SW-2:VALUE_W] != '0) begin
					new_value = '1;
				end else begin
					new_value = sum[VALUE_W-1:0];
				end
				if (alg_q == ALG_BINARY && new_step == 16'd1) begin
					new_done = 1'b1;
				end
			end
		endcase
		if (mode_q == MODE_INIT) begin
			new_value = max_q;
			new_step  = init_step_q;
			new_prior = SIGN_MINUS;
			new_done  = 1'b0;
		end
	end

	// Write back the channel's state.
	always_ff @(posedge clk) begin
		if (cmd.compute && in_range_q) begin
			value_mem[wr_addr] <= new_value;
			step_mem[wr_addr]  <= new_step;
			prior_mem[wr_addr] <= new_prior;
			done_mem[wr_addr]  <= new_done;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.compute) begin
			out_channel  <= channel_q;
			tuned_value  <= in_range_q ? new_value : '0;
			current_step <= in_range_q ? new_step : '0;
			channel_done <= in_range_q & new_done;
		end
	end

endmodule

@@ hw/rtl/per_channel_dac_feedback_tuner_top.sv @@
// Channel  Role    Beat contents
// in_ch    sink    mode, channel, sign, last
// out_ch   source  out_channel, tuned_value, current_step, channel_done
// cfg      write   cfg_we, cfg_index, cfg_data (min, max, initial step, algorithm)
//
// Each item is first captured, with the channel's state read from the
// per-channel memories, and then computed and written back.
// A result waits in the output register while the next item is taken; the
// update stage holds while that register is still full.
// Reset puts the controller and the configuration registers in their reset state;
// the channel memories hold nothing defined until a channel is initialized.
module per_channel_dac_feedback_tuner_top
	import pcdft_pkg::*;
#(
	parameter int CHANNELS = PCDFT_CHANNELS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	pcdft_in_if.sink               in_ch,
	pcdft_out_if.source            out_ch
);

	cmd_t cmd;

	pcdft_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd)
	);

	pcdft_dp #(
		.CHANNELS (CHANNELS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mode         (in_ch.mode),
		.channel      (in_ch.channel),
		.sign         (in_ch.sign),
		.last         (in_ch.last),
		.out_channel  (out_ch.out_channel),
		.tuned_value  (out_ch.tuned_value),
		.current_step (out_ch.current_step),
		.channel_done (out_ch.channel_done)
	);

endmodule

@@ hw/rtl/pcdft_checker.sv @@
module pcdft_checker
	import pcdft_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [CHANNEL_W-1:0] out_channel,
	input logic [VALUE_W-1:0]   tuned_value
);

	// A waiting result stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// A waiting result holds its channel and tuned value.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_channel) && $stable(tuned_value))
		else $error("result payload changed while stalled");

	// Only one item is in the update stage at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while another is in update");

	// After an accepted item and the update state that follows it, a result is on offer,
	// either its own one or an earlier one that is still waiting on the output.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##2 out_valid)
		else $error("no result after an accepted item");

endmodule

bind per_channel_dac_feedback_tuner_top pcdft_checker u_pcdft_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.out_channel (out_ch.out_channel),
	.tuned_value (out_ch.tuned_value)
);

@@ sim/tb_top.sv @@
module tb_top;
	import pcdft_pkg::*;

	// Codes the package leaves unnamed: the spare algorithm and the spare sign pattern.
	localparam logic [ALG_W-1:0]  ALG_SPARE  = 2'd3;
	localparam logic [SIGN_W-1:0] SIGN_SPARE = 2'b10;
	localparam int IDLE_LIMIT    = 2000;
	localparam int PHASES        = 8;
	localparam int PHASE_BEATS   = 128;

	// One expected channel update.
	typedef struct packed {
		logic [CHANNEL_W-1:0] ch;
		logic [VALUE_W-1:0]   value;
		logic [VALUE_W-1:0]   step;
		logic                 done;
	} chan_update_t;

	// Mirror of the tuner state; predicts each update and checks the reported one.
	class tuning_book;
		logic [VALUE_W-1:0] min_level;
		logic [VALUE_W-1:0] max_level;
		logic [VALUE_W-1:0] start_step;
		logic [ALG_W-1:0]   alg;
		logic [VALUE_W-1:0] value_mem[PCDFT_CHANNELS];
		logic [VALUE_W-1:0] step_mem[PCDFT_CHANNELS];
		int                 prior_mem[PCDFT_CHANNELS];
		bit                 done_mem[PCDFT_CHANNELS];
		chan_update_t       due_updates[$];
		int errors;
		int inits;
		int feedbacks;
		int finished_reports;

		function new();
			min_level = MIN_RESET;
			max_level = MAX_RESET;
			start_step = STEP_RESET;
			alg = ALG_SIGN_CHANGE;
			errors = 0;
			inits = 0;
			feedbacks = 0;
			finished_reports = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_MIN_VALUE: min_level = data;
				CFG_MAX_VALUE: max_level = data;
				CFG_INITIAL_STEP: start_step = data;
				CFG_ALGORITHM: alg = data[ALG_W-1:0];
				default: ;
			endcase
		endfunction

		function int sat16(int v);
			if (v < 0)
				return 0;
			if (v > 65535)
				return 65535;
			return v;
		endfunction

		function int pending();
			return due_updates.size();
		endfunction

		function bit finished(logic [CHANNEL_W-1:0] ch);
			return done_mem[ch];
		endfunction

		// Apply one accepted beat to the mirrored state and queue its update.
		function void predict_update(logic mode, logic [CHANNEL_W-1:0] ch,
				logic [SIGN_W-1:0] sgn, logic last);
			int s;
			int val;
			int stp;
			int lo;
			int hi;
			bit done;
			chan_update_t u;
			s = (sgn == SIGN_NONE) ? 0 : (sgn == SIGN_PLUS) ? 1 : -1;
			lo = int'(min_level);
			hi = int'(max_level);
			u = '0;
			u.ch = ch;
			if (ch < PCDFT_CHANNELS) begin
				if (mode == MODE_INIT) begin
					value_mem[ch] = max_level;
					step_mem[ch] = start_step;
					prior_mem[ch] = -1;
					done_mem[ch] = 1'b0;
					inits++;
				end else begin
					val = int'(value_mem[ch]);
					stp = int'(step_mem[ch]);
					done = done_mem[ch] | last;
					case (alg)
						ALG_SIGN_CHANGE: begin
							// A sign change halves the step and forgets the sign.
							if (s != prior_mem[ch]) begin
								prior_mem[ch] = 0;
								stp = stp / 2;
							end
							val = val + stp * s;
							if (val > hi)
								val = hi;
							if (val < lo)
								val = lo;
							if (stp == 1 || val <= lo)
								done = 1'b1;
						end
						ALG_BINARY: begin
							val = sat16(val + stp * s);
							stp = stp / 2;
							if (stp == 1)
								done = 1'b1;
						end
						default: begin
							val = sat16(val + s);
						end
					endcase
					value_mem[ch] = val[VALUE_W-1:0];
					step_mem[ch] = stp[VALUE_W-1:0];
					done_mem[ch] = done;
					feedbacks++;
				end
				u.value = value_mem[ch];
				u.step = step_mem[ch];
				u.done = done_mem[ch];
			end
			due_updates.insert(due_updates.size(), u);
		endfunction

		function void check_field(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
				errors++;
			end
		endfunction

		// Compare a reported update with the oldest expected one.
		function void check_update(logic [CHANNEL_W-1:0] ch, logic [VALUE_W-1:0] val,
				logic [VALUE_W-1:0] stp, logic done);
			chan_update_t want;
			if (due_updates.size() == 0) begin
				$display("%0t: unexpected update, expected none, actual channel %0d value %0d",
					$time, ch, val);
				errors++;
				return;
			end
			want = due_updates.pop_front();
			check_field("out_channel", 32'(want.ch), 32'(ch));
			check_field("tuned_value", 32'(want.value), 32'(val));
			check_field("current_step", 32'(want.step), 32'(stp));
			check_field("channel_done", 32'(want.done), 32'(done));
			if (want.done)
				finished_reports++;
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	bit                     calm;
	bit                     opened[PCDFT_CHANNELS];
	int                     settings;
	int                     idle_cycles;
	tuning_book             book = new();

	pcdft_in_if  in_ch();
	pcdft_out_if out_ch();

	per_channel_dac_feedback_tuner_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	always #5 clk = ~clk;

	// Result side: random stall bursts unless the run is in a calm stretch.
	initial begin
		int stall;
		stall = 0;
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				out_ch.ready = 1'b0;
				stall--;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_ch.ready = 1'b0;
				stall = $urandom_range(0, 8);
			end else begin
				out_ch.ready = 1'b1;
			end
		end
	end

	// Check every accepted result beat.
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			book.check_update(out_ch.out_channel, out_ch.tuned_value, out_ch.current_step,
				out_ch.channel_done);
	end

	// Watchdog on cycles with no beat on either channel.
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no beat for %0d cycles at %0t.", IDLE_LIMIT, $time);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Offer one input beat, with an optional gap before it; returns at the next falling edge.
	task automatic send_beat(logic mode, logic [CHANNEL_W-1:0] ch, logic [SIGN_W-1:0] sgn,
			logic last);
		int gap;
		gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 9) : 0;
		if (gap > 0) begin
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.mode = mode;
		in_ch.channel = ch;
		in_ch.sign = sgn;
		in_ch.last = last;
		if (mode == MODE_INIT)
			opened[ch] = 1'b1;
		do
			@(posedge clk);
		while (!in_ch.ready);
		book.predict_update(mode, ch, sgn, last);
		@(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		book.write_reg(idx, data);
	endtask

	// Wait for the tuner to drain, then load all four registers.
	task automatic set_tuning(logic [VALUE_W-1:0] lo, logic [VALUE_W-1:0] hi,
			logic [VALUE_W-1:0] stride, logic [ALG_W-1:0] alg_code);
		logic [CFG_DATA_W-1:0] alg_word;
		in_ch.valid = 1'b0;
		while (book.pending() != 0)
			@(negedge clk);
		alg_word = CFG_DATA_W'($urandom);
		alg_word[ALG_W-1:0] = alg_code;
		write_reg(CFG_MIN_VALUE, lo);
		write_reg(CFG_MAX_VALUE, hi);
		write_reg(CFG_INITIAL_STEP, stride);
		write_reg(CFG_ALGORITHM, alg_word);
		cfg_we = 1'b0;
		settings++;
	endtask

	initial begin
		int p;
		int n;
		int roll;
		logic [CHANNEL_W-1:0] base;
		logic [CHANNEL_W-1:0] ch;
		logic [VALUE_W-1:0] lo;
		logic [VALUE_W-1:0] hi;
		logic [VALUE_W-1:0] stride;
		logic [ALG_W-1:0] alg_code;
		logic [SIGN_W-1:0] sgn;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_MIN_VALUE;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.mode = MODE_INIT;
		in_ch.channel = '0;
		in_ch.sign = SIGN_NONE;
		in_ch.last = 1'b0;
		calm = 1'b0;
		settings = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Sign-change halving: equal sign keeps the step, a change halves it, done on last.
		set_tuning(16'd10, 16'd200, 16'd64, ALG_SIGN_CHANGE);
		send_beat(MODE_INIT, 5'd0, SIGN_SPARE, 1'b1);
		send_beat(MODE_FEEDBACK, 5'd0, SIGN_MINUS, 1'b0);
		send_beat(MODE_FEEDBACK, 5'd0, SIGN_PLUS, 1'b0);
		send_beat(MODE_FEEDBACK, 5'd0, SIGN_NONE, 1'b0);
		send_beat(MODE_FEEDBACK, 5'd0, SIGN_SPARE, 1'b0);
		send_beat(MODE_FEEDBACK, 5'd0, SIGN_NONE, 1'b1);
		send_beat(MODE_INIT, 5'd31, SIGN_PLUS, 1'b0);
		send_beat(MODE_FEEDBACK, 5'd31, SIGN_PLUS, 1'b0);

		// Lower clamp above the upper one: the value lands on the lower clamp.
		set_tuning(16'd300, 16'd100, 16'd8, ALG_SIGN_CHANGE);
		send_beat(MODE_INIT, 5'd1, SIGN_NONE, 1'b0);
		send_beat(MODE_FEEDBACK, 5'd1, SIGN_MINUS, 1'b0);

		// Binary halving saturating at zero and at full scale.
		set_tuning(16'd0, 16'd0, 16'hFFFF, ALG_BINARY);
		send_beat(MODE_INIT, 5'd3, SIGN_MINUS, 1'b0);
		send_beat(MODE_FEEDBACK, 5'd3, SIGN_MINUS, 1'b0);
		send_beat(MODE_FEEDBACK, 5'd3, SIGN_PLUS, 1'b0);
		set_tuning(16'd0, 16'hFFFF, 16'hFFFF, ALG_BINARY);
		send_beat(MODE_INIT, 5'd2, SIGN_NONE, 1'b0);
		send_beat(MODE_FEEDBACK, 5'd2, SIGN_PLUS, 1'b0);
		send_beat(MODE_FEEDBACK, 5'd2, SIGN_SPARE, 1'b0);

		// Unit step, and the spare algorithm code acting as unit step.
		set_tuning(16'hFFFF, 16'hFFFF, 16'd0, ALG_UNIT);
		send_beat(MODE_INIT, 5'd4, SIGN_NONE, 1'b0);
		send_beat(MODE_FEEDBACK, 5'd4, SIGN_PLUS, 1'b0);
		send_beat(MODE_FEEDBACK, 5'd4, SIGN_MINUS, 1'b0);
		send_beat(MODE_FEEDBACK, 5'd4, SIGN_NONE, 1'b1);
		set_tuning(16'd0, 16'd0, 16'd2, ALG_SPARE);
		send_beat(MODE_INIT, 5'd6, SIGN_PLUS, 1'b1);
		send_beat(MODE_FEEDBACK, 5'd6, SIGN_MINUS, 1'b0);
		send_beat(MODE_FEEDBACK, 5'd6, SIGN_SPARE, 1'b0);
		send_beat(MODE_FEEDBACK, 5'd6, SIGN_PLUS, 1'b0);

		// Random phases: tuning runs on a few neighboring channels, re-inited now and then.
		for (p = 0; p < PHASES; p++) begin
			calm = (p == 3 || p == PHASES - 1);
			alg_code = ALG_W'((p < 4) ? p : $urandom_range(0, 3));
			roll = $urandom_range(0, 7);
			lo = VALUE_W'((roll < 3) ? 0 : (roll < 6) ? $urandom_range(1, 200) :
				(roll == 6) ? $urandom_range(0, 65535) : 65535);
			roll = $urandom_range(0, 7);
			hi = VALUE_W'((roll < 2) ? 255 : (roll < 5) ? $urandom_range(256, 65535) :
				(roll == 5) ? 65535 : (roll == 6) ? $urandom_range(0, 255) : 0);
			roll = $urandom_range(0, 7);
			stride = VALUE_W'((roll < 2) ? (1 << $urandom_range(1, 15)) :
				(roll < 4) ? $urandom_range(2, 512) : (roll == 4) ? $urandom_range(0, 65535) :
				(roll == 5) ? 65535 : (roll == 6) ? $urandom_range(0, 1) : int'(hi));
			set_tuning(lo, hi, stride, alg_code);
			base = CHANNEL_W'($urandom_range(0, 31));
			for (n = 0; n < PHASE_BEATS; n++) begin
				if (n % 32 == 31)
					base = CHANNEL_W'($urandom_range(0, 31));
				ch = CHANNEL_W'(int'(base) + $urandom_range(0, 3));
				if ($urandom_range(0, 9) == 0)
					ch = CHANNEL_W'($urandom_range(0, 31));
				if (!opened[ch] || $urandom_range(0, 11) == 0 ||
						(book.finished(ch) && $urandom_range(0, 1) == 0)) begin
					send_beat(MODE_INIT, ch, SIGN_W'($urandom), 1'($urandom));
				end else begin
					roll = $urandom_range(0, 9);
					sgn = (roll < 4) ? SIGN_PLUS : (roll < 8) ? SIGN_MINUS :
						(roll == 8) ? SIGN_NONE : SIGN_SPARE;
					send_beat(MODE_FEEDBACK, ch, sgn, $urandom_range(0, 15) == 0);
				end
			end
		end

		// Drain, then wait for any stray result.
		in_ch.valid = 1'b0;
		while (book.pending() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);

		$display("Covered %0d init and %0d feedback beats over %0d register settings.",
			book.inits, book.feedbacks, settings);
		$display("%0d updates reported a finished channel; %0d mismatches seen.",
			book.finished_reports, book.errors);
		if (book.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
